@@ rtl/dsbf_pkg.sv @@
// shared constants, codes and controller/datapath interface types
package dsbf_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam logic [31:0] LEASE_RESET = 32'd3600;

	localparam logic [7:0] MSG_OFFER   = 8'd2;
	localparam logic [7:0] MSG_REQUEST = 8'd3;
	localparam logic [7:0] MSG_ACK     = 8'd5;
	localparam logic [7:0] MSG_RELEASE = 8'd7;

	localparam logic [1:0] VERDICT_ALLOW     = 2'd0;
	localparam logic [1:0] VERDICT_UNTRUSTED = 2'd1;
	localparam logic [1:0] VERDICT_INVALID   = 2'd2;

	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_ADDED   = 3'd1;
	localparam logic [2:0] ACT_REFRESH = 3'd2;
	localparam logic [2:0] ACT_REMOVED = 3'd3;
	localparam logic [2:0] ACT_FULL    = 3'd4;

	localparam int KEY_W = 48 + 32 + 4;

	typedef struct packed {
		logic load;
		logic tick;
		logic scan;
		logic apply;
	} dsbf_cmd_t;

	typedef struct packed {
		logic scan_last;
	} dsbf_stat_t;

endpackage

@@ rtl/dsbf_ram.sv @@
// generic single-write, single-read ram with registered read data
module dsbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ rtl/dsbf_ctrl.sv @@
// controller state machine: accept, table scan, apply
module dsbf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 kind,
	input  dsbf_pkg::dsbf_stat_t stat,
	output dsbf_pkg::dsbf_cmd_t  cmd,
	output logic                 busy
);
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (kind) begin
						cmd.tick = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

@@ rtl/dsbf_datapath.sv @@
// datapath: item registers, binding table, scan compare and table update
module dsbf_datapath #(
	parameter int TABLE_ENTRIES = dsbf_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dsbf_pkg::dsbf_cmd_t  cmd,
	output dsbf_pkg::dsbf_stat_t stat,
	input  logic [7:0]           msg_type,
	input  logic                 trusted,
	input  logic [3:0]           port,
	input  logic [47:0]          client_mac,
	input  logic                 requested_present,
	input  logic [31:0]          req_ip,
	input  logic [31:0]          offered_ip,
	input  logic                 lease_present,
	input  logic [31:0]          lease_seconds,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_data,
	output logic                 result_valid,
	output logic [1:0]           verdict,
	output logic [2:0]           binding_action
);
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] CNT_END = CW'(TABLE_ENTRIES);
	localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_ENTRIES - 1);

	// item registers
	logic [7:0]  type_q;
	logic        trusted_q;
	logic [3:0]  port_q;
	logic [47:0] mac_q;
	logic        req_present_q;
	logic [31:0] req_ip_q;
	logic [31:0] off_ip_q;
	logic [31:0] lease_q;

	logic [31:0] default_lease_q;
	logic [31:0] now_q;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [IW-1:0]            rank_q [TABLE_ENTRIES];

	logic [CW-1:0] cnt_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;

	// scan results
	logic          found_q;
	logic [IW-1:0] best_idx_q;
	logic [IW-1:0] best_rank_q;
	logic          live_hit_q;
	logic          free_found_q;
	logic [IW-1:0] free_idx_q;

	logic                        rd_issue;
	logic [dsbf_pkg::KEY_W-1:0]  key_rd;
	logic [31:0]                 exp_rd;
	logic [dsbf_pkg::KEY_W-1:0]  key_wr;
	logic                        key_we;
	logic                        exp_we;
	logic [IW-1:0]               waddr;

	logic ent_valid;
	logic [IW-1:0] ent_rank;
	logic mac_eq, req_eq, off_eq, port_eq, live, live_cand, newest_cand;

	logic [32:0] exp_sum;
	logic [31:0] exp_new;
	logic        do_remove, do_add, do_refresh;
	logic [1:0]  verdict_d;
	logic [2:0]  action_d;

	assign rd_issue = cmd.scan && (cnt_q != CNT_END);
	assign stat.scan_last = rd_vld_s1 && (rd_idx_s1 == IDX_LAST);

	dsbf_ram #(.WIDTH(dsbf_pkg::KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (waddr),
		.wdata (key_wr),
		.re    (rd_issue),
		.raddr (cnt_q[IW-1:0]),
		.rdata (key_rd)
	);

	dsbf_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_exp_ram (
		.clk   (clk),
		.we    (exp_we),
		.waddr (waddr),
		.wdata (exp_new),
		.re    (rd_issue),
		.raddr (cnt_q[IW-1:0]),
		.rdata (exp_rd)
	);

	// per-entry compare on the word read last cycle
	always_comb begin
		ent_valid   = valid_q[rd_idx_s1];
		ent_rank    = rank_q[rd_idx_s1];
		mac_eq      = (key_rd[83:36] == mac_q);
		req_eq      = (key_rd[35:4] == req_ip_q);
		off_eq      = (key_rd[35:4] == off_ip_q);
		port_eq     = (key_rd[3:0] == port_q);
		live        = (exp_rd > now_q);
		live_cand   = ent_valid && mac_eq && req_eq && port_eq && live;
		// ack looks for mac and ip, release for mac alone
		newest_cand = ent_valid && mac_eq && (!trusted_q || off_eq);
	end

	// expiry for add or refresh, saturating
	assign exp_sum = {1'b0, now_q} + {1'b0, lease_q};
	assign exp_new = exp_sum[32] ? '1 : exp_sum[31:0];
	assign key_wr  = {mac_q, off_ip_q, port_q};

	always_comb begin
		verdict_d  = dsbf_pkg::VERDICT_ALLOW;
		action_d   = dsbf_pkg::ACT_NONE;
		do_remove  = 1'b0;
		do_add     = 1'b0;
		do_refresh = 1'b0;
		if (!trusted_q) begin
			if (type_q == dsbf_pkg::MSG_OFFER || type_q == dsbf_pkg::MSG_ACK) begin
				verdict_d = dsbf_pkg::VERDICT_UNTRUSTED;
			end else if (type_q == dsbf_pkg::MSG_REQUEST) begin
				if (req_present_q && !live_hit_q) begin
					verdict_d = dsbf_pkg::VERDICT_INVALID;
				end
			end else if (type_q == dsbf_pkg::MSG_RELEASE) begin
				if (found_q) begin
					do_remove = 1'b1;
					action_d  = dsbf_pkg::ACT_REMOVED;
				end
			end
		end else if (type_q == dsbf_pkg::MSG_ACK) begin
			if (found_q) begin
				do_refresh = 1'b1;
				action_d   = dsbf_pkg::ACT_REFRESH;
			end else if (free_found_q) begin
				do_add   = 1'b1;
				action_d = dsbf_pkg::ACT_ADDED;
			end else begin
				action_d = dsbf_pkg::ACT_FULL;
			end
		end
	end

	assign key_we = cmd.apply && do_add;
	assign exp_we = cmd.apply && (do_add || do_refresh);
	assign waddr  = do_add ? free_idx_q : best_idx_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_lease_q <= dsbf_pkg::LEASE_RESET;
			now_q           <= '0;
			valid_q         <= '0;
			cnt_q           <= '0;
			rd_vld_s1       <= 1'b0;
			result_valid    <= 1'b0;
		end else begin
			if (cfg_we) begin
				default_lease_q <= cfg_data;
			end
			if (cmd.tick && (now_q != '1)) begin
				now_q <= now_q + 32'd1;
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (rd_issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			rd_vld_s1    <= rd_issue;
			result_valid <= cmd.apply;
			if (cmd.apply && do_remove) begin
				valid_q[best_idx_q] <= 1'b0;
			end
			if (cmd.apply && do_add) begin
				valid_q[free_idx_q] <= 1'b1;
			end
		end
	end

	// payload and scan bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q        <= msg_type;
			trusted_q     <= trusted;
			port_q        <= port;
			mac_q         <= client_mac;
			req_present_q <= requested_present;
			req_ip_q      <= req_ip;
			off_ip_q      <= offered_ip;
			lease_q       <= lease_present ? lease_seconds : default_lease_q;
			found_q       <= 1'b0;
			live_hit_q    <= 1'b0;
			free_found_q  <= 1'b0;
			best_idx_q    <= '0;
			best_rank_q   <= '0;
			free_idx_q    <= '0;
		end
		rd_idx_s1 <= cnt_q[IW-1:0];
		if (rd_vld_s1) begin
			if (live_cand) begin
				live_hit_q <= 1'b1;
			end
			if (newest_cand && (!found_q || ent_rank < best_rank_q)) begin
				found_q     <= 1'b1;
				best_idx_q  <= rd_idx_s1;
				best_rank_q <= ent_rank;
			end
			if (!ent_valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= rd_idx_s1;
			end
		end
		if (cmd.apply) begin
			verdict        <= verdict_d;
			binding_action <= action_d;
		end
		// age ranks move together on remove and add
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (cmd.apply && do_remove && valid_q[i] && (rank_q[i] > best_rank_q)) begin
				rank_q[i] <= rank_q[i] - IW'(1);
			end
			if (cmd.apply && do_add) begin
				if (IW'(i) == free_idx_q) begin
					rank_q[i] <= '0;
				end else if (valid_q[i]) begin
					rank_q[i] <= rank_q[i] + IW'(1);
				end
			end
		end
	end
endmodule

@@ rtl/dhcp_snooping_binding_filter.sv @@
// top level of the dhcp snooping binding filter
//
// usage:
// - an item (parsed dhcp message or one-second tick) is taken at a clock edge
//   where start is high and busy is low; all payload ports are sampled there
// - a tick bumps the seconds count (saturating), gives no result and leaves
//   busy low, so another item may follow in the next cycle
// - a message scans every binding entry, one ram read per cycle, then applies
//   its verdict and table change in the apply state
// - result_valid is registered from the apply state and is high for exactly
//   one cycle; busy drops in that same cycle, so a message occupies the block
//   through the scan and apply states; the scan length is set by the single
//   read port of the entry ram
// - results carry verdict and binding_action; the receiver cannot stall and
//   must take each result in the cycle it is shown
// - default_lease is written through cfg_valid/cfg_ready/cfg_data; cfg_ready
//   is always high, writes are meant to happen while idle
// - reset (arst_n low) empties the table, clears the seconds count and sets
//   default_lease to 3600; no clearing pass is needed
module dhcp_snooping_binding_filter #(
	parameter int TABLE_ENTRIES = dsbf_pkg::TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [7:0]  msg_type,
	input  logic        trusted,
	input  logic [3:0]  port,
	input  logic [47:0] client_mac,
	input  logic        requested_present,
	input  logic [31:0] req_ip,
	input  logic [31:0] offered_ip,
	input  logic        lease_present,
	input  logic [31:0] lease_seconds,
	// result channel
	output logic        result_valid,
	output logic [1:0]  verdict,
	output logic [2:0]  binding_action,
	// default lease register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	dsbf_pkg::dsbf_cmd_t  cmd;
	dsbf_pkg::dsbf_stat_t stat;

	// register always writable
	assign cfg_ready = 1'b1;

	// sequencing: idle, scan, apply
	dsbf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// table, compare and update logic
	dsbf_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.msg_type          (msg_type),
		.trusted           (trusted),
		.port              (port),
		.client_mac        (client_mac),
		.requested_present (requested_present),
		.req_ip            (req_ip),
		.offered_ip        (offered_ip),
		.lease_present     (lease_present),
		.lease_seconds     (lease_seconds),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_data          (cfg_data),
		.result_valid      (result_valid),
		.verdict           (verdict),
		.binding_action    (binding_action)
	);
endmodule

@@ rtl/dsbf_checker.sv @@
// port-level checker for the binding filter, bound to the top level
module dsbf_port_checks (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       kind,
	input logic       result_valid,
	input logic [1:0] verdict,
	input logic [2:0] binding_action
);
	// a result only closes a message that held the block
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without a message in flight");

	// a message makes the block busy
	a_msg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !kind) |=> busy)
		else $error("message accepted but block not busy");

	// a tick gives no result and keeps the block free
	a_tick_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind) |=> (!busy && !result_valid))
		else $error("tick occupied the block");

	// a blocked message never changes the table
	a_block_no_action: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && verdict != dsbf_pkg::VERDICT_ALLOW)
			|-> (binding_action == dsbf_pkg::ACT_NONE))
		else $error("blocked message changed the table");
endmodule

bind dhcp_snooping_binding_filter dsbf_port_checks u_dsbf_port_checks (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.kind           (kind),
	.result_valid   (result_valid),
	.verdict        (verdict),
	.binding_action (binding_action)
);
